### rtl/core/bavg_pkg.sv
// Shared types, constants and state codes of the block-average downsampler.
`default_nettype none

package bavg_pkg;

  // Grid and image limits
  localparam int OUT_COLS = 64;
  localparam int OUT_ROWS = 64;
  localparam int MAX_DIM  = 4096;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int DIM_W    = 13;
  localparam int HS_W     = 10;
  localparam int GRID_W   = 6;
  localparam int HEIGHT_W = 18;
  localparam int FRAC_W   = 8;

  // Derived counter widths
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int COL_SHIFT   = $clog2(OUT_COLS);
  localparam int ROW_SHIFT   = $clog2(OUT_ROWS);
  localparam int COL_BIN_W   = $clog2(MAX_DIM / OUT_COLS);
  localparam int ROW_BIN_W   = $clog2(MAX_DIM / OUT_ROWS);
  localparam int BW_W        = COL_BIN_W + 1;
  localparam int BH_W        = ROW_BIN_W + 1;
  localparam int COL_IDX_W   = $clog2(OUT_COLS);
  localparam int BCOL_W      = COL_IDX_W + 1;
  localparam int BROW_W      = $clog2(OUT_ROWS) + 1;

  // Arithmetic widths
  localparam int SUM_W   = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int PROD_W  = SUM_W + HS_W;
  localparam int NUM_W   = PROD_W + FRAC_W;
  localparam int AREA_W  = BW_W + BH_W;
  localparam int DEN_W   = AREA_W + 8;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  // Configuration register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_IN_WIDTH     = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  localparam logic [DIM_W-1:0] IN_WIDTH_RST     = 13'd256;
  localparam logic [DIM_W-1:0] IN_HEIGHT_RST    = 13'd256;
  localparam logic [HS_W-1:0]  HEIGHT_SCALE_RST = 10'd1;

  // Frame geometry after clamping
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [BW_W-1:0]  bw;
    logic [BH_W-1:0]  bh;
  } geom_t;

  // What one pixel does to the sums
  typedef struct packed {
    logic              acc;
    logic              emit;
    logic              last;
    logic [GRID_W-1:0] grid_row;
    logic [GRID_W-1:0] grid_col;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/bavg_if.sv
// Handshake channels: pixel words in, height words out.
`default_nettype none

interface bavg_pix_if;
  import bavg_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bavg_res_if;
  import bavg_pkg::*;
  logic                valid;
  logic                ready;
  logic [GRID_W-1:0]   grid_row;
  logic [GRID_W-1:0]   grid_col;
  logic [HEIGHT_W-1:0] height;
  logic                last_of_frame;

  modport source (output valid, output grid_row, output grid_col, output height,
                  output last_of_frame, input ready);
  modport sink   (input valid, input grid_row, input grid_col, input height,
                  input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/bavg_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/bavg_raster.sv
// Raster position and block position counters.
`default_nettype none

module bavg_raster (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic                    frame_start,
  input  wire bavg_pkg::geom_t         geom,
  output bavg_pkg::op_t                op
);
  import bavg_pkg::*;

  logic [POS_W-1:0]     pixel_col, pixel_col_next;
  logic [POS_W-1:0]     pixel_row, pixel_row_next;
  logic [COL_BIN_W-1:0] col_in_block, col_in_block_next;
  logic [ROW_BIN_W-1:0] row_in_block, row_in_block_next;
  logic [BCOL_W-1:0]    block_col_index, block_col_index_next;
  logic [BROW_W-1:0]    block_row_index, block_row_index_next;

  logic [POS_W-1:0]     cur_pc, cur_pr;
  logic [COL_BIN_W-1:0] cur_cib;
  logic [ROW_BIN_W-1:0] cur_rib;
  logic [BCOL_W-1:0]    cur_bci;
  logic [BROW_W-1:0]    cur_bri;
  logic                 col_end, row_end, col_wrap, row_wrap, in_grid;

  // Frame start clears the counters before this pixel is placed
  always_comb begin
    cur_pc  = frame_start ? '0 : pixel_col;
    cur_pr  = frame_start ? '0 : pixel_row;
    cur_cib = frame_start ? '0 : col_in_block;
    cur_rib = frame_start ? '0 : row_in_block;
    cur_bci = frame_start ? '0 : block_col_index;
    cur_bri = frame_start ? '0 : block_row_index;

    col_end  = ({1'b0, cur_cib} + BW_W'(1)) >= geom.bw;
    row_end  = ({1'b0, cur_rib} + BH_W'(1)) >= geom.bh;
    col_wrap = ({1'b0, cur_pc} + DIM_W'(1)) >= geom.w;
    row_wrap = ({1'b0, cur_pr} + DIM_W'(1)) >= geom.h;
    in_grid  = (cur_bci < BCOL_W'(OUT_COLS)) && (cur_bri < BROW_W'(OUT_ROWS));

    op.acc      = (geom.bw != '0) && (geom.bh != '0) && in_grid;
    op.emit     = op.acc && col_end && row_end;
    op.last     = (cur_bri == BROW_W'(OUT_ROWS - 1)) && (cur_bci == BCOL_W'(OUT_COLS - 1));
    op.grid_row = cur_bri[GRID_W-1:0];
    op.grid_col = cur_bci[GRID_W-1:0];
  end

  // Advance in raster order; margin pixels park the grid index at its limit
  always_comb begin
    pixel_col_next       = cur_pc;
    pixel_row_next       = cur_pr;
    col_in_block_next    = cur_cib;
    row_in_block_next    = cur_rib;
    block_col_index_next = cur_bci;
    block_row_index_next = cur_bri;
    if (col_wrap) begin
      pixel_col_next       = '0;
      col_in_block_next    = '0;
      block_col_index_next = '0;
      if (row_wrap) begin
        pixel_row_next       = '0;
        row_in_block_next    = '0;
        block_row_index_next = '0;
      end else begin
        pixel_row_next = cur_pr + POS_W'(1);
        if (geom.bh != '0) begin
          if (row_end) begin
            row_in_block_next = '0;
            if (cur_bri < BROW_W'(OUT_ROWS)) begin
              block_row_index_next = cur_bri + BROW_W'(1);
            end
          end else begin
            row_in_block_next = cur_rib + ROW_BIN_W'(1);
          end
        end
      end
    end else begin
      pixel_col_next = cur_pc + POS_W'(1);
      if (geom.bw != '0) begin
        if (col_end) begin
          col_in_block_next = '0;
          if (cur_bci < BCOL_W'(OUT_COLS)) begin
            block_col_index_next = cur_bci + BCOL_W'(1);
          end
        end else begin
          col_in_block_next = cur_cib + COL_BIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col       <= '0;
      pixel_row       <= '0;
      col_in_block    <= '0;
      row_in_block    <= '0;
      block_col_index <= '0;
      block_row_index <= '0;
    end else if (accept) begin
      pixel_col       <= pixel_col_next;
      pixel_row       <= pixel_row_next;
      col_in_block    <= col_in_block_next;
      row_in_block    <= row_in_block_next;
      block_col_index <= block_col_index_next;
      block_row_index <= block_row_index_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bavg_divider.sv
// Restoring divider, one quotient bit per cycle, result capped.
`default_nettype none

module bavg_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bavg_pkg::NUM_W-1:0]    num,
  input  wire logic [bavg_pkg::DEN_W-1:0]    den,
  input  wire logic [bavg_pkg::HEIGHT_W-1:0] cap,
  output logic                               done,
  output logic      [bavg_pkg::HEIGHT_W-1:0] quot
);
  import bavg_pkg::*;

  logic [NUM_W-1:0]    dvd;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W-1:0]    den_r;
  logic [HEIGHT_W-1:0] cap_r;
  logic [HEIGHT_W-1:0] q;
  logic                ovf;
  logic [STEP_W-1:0]   steps;
  logic                busy;

  logic [DEN_W:0]      trial;
  logic                ge;
  logic [DEN_W:0]      diff;
  logic [DEN_W-1:0]    rem_next;

  // One trial subtraction
  always_comb begin
    trial    = {rem, dvd[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Quotient bits that leave the top mean the result is past any cap
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= num;
      rem   <= '0;
      den_r <= den;
      cap_r <= cap;
      q     <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[NUM_W-2:0], 1'b0};
      rem <= rem_next;
      q   <= {q[HEIGHT_W-2:0], ge};
      ovf <= ovf | q[HEIGHT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot = (ovf || (q > cap_r)) ? cap_r : q;

endmodule

`default_nettype wire

### rtl/core/block_average_image_downsampler.sv
// Top level: configuration registers, sum memory sequencer and result register.
//
// Grayscale pixels arrive in raster order and are summed per grid column in a 64-entry
// memory, one read-modify-write per pixel; a completed block is scaled as
// floor(sum * height_scale * 256 / (255 * block_h * block_w)), capped at
// height_scale * 256. A pixel that completes no block is accepted with a memory read,
// then updated and written back before the next pixel is accepted. A pixel that completes
// a block then passes through the multiply and the 38-step restoring divider, plus any
// wait for the result register to be taken. The result register lets the next pixel be
// accepted while a height word waits downstream. Geometry registers may only be written
// while idle. No clearing pass is needed after reset: per-entry valid bits make unwritten
// sums read as zero.
`default_nettype none

module block_average_image_downsampler (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bavg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bavg_pkg::PDATA_W-1:0] pwdata,
  output logic      [bavg_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  bavg_pix_if.sink                          pixels,
  bavg_res_if.source                        heights
);
  import bavg_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0] in_width;
  logic [DIM_W-1:0] in_height;
  logic [HS_W-1:0]  height_scale;
  logic             cfg_write;
  logic [1:0]       reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width     <= IN_WIDTH_RST;
      in_height    <= IN_HEIGHT_RST;
      height_scale <= HEIGHT_SCALE_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_IN_WIDTH:     in_width     <= pwdata[DIM_W-1:0];
        REG_IN_HEIGHT:    in_height    <= pwdata[DIM_W-1:0];
        REG_HEIGHT_SCALE: height_scale <= pwdata[HS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IN_WIDTH:     prdata = PDATA_W'(in_width);
      REG_IN_HEIGHT:    prdata = PDATA_W'(in_height);
      REG_HEIGHT_SCALE: prdata = PDATA_W'(height_scale);
      default:          prdata = '0;
    endcase
  end

  // Clamped geometry and block size
  geom_t geom;
  always_comb begin
    geom.w  = (in_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_width;
    geom.h  = (in_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_height;
    geom.bw = BW_W'(geom.w >> COL_SHIFT);
    geom.bh = BH_W'(geom.h >> ROW_SHIFT);
  end

  // Sequencer
  state_t state, state_next;
  logic   accept, ram_we, div_start, out_load;
  op_t    op_cur, op;
  logic   div_done;
  logic [HEIGHT_W-1:0] div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    pixels.ready   = 1'b0;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        pixels.ready = 1'b1;
        if (pixels.valid) begin
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        ram_we     = op.acc;
        state_next = op.emit ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!heights.valid || heights.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = pixels.valid && pixels.ready;

  bavg_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (pixels.frame_start),
    .geom        (geom),
    .op          (op_cur)
  );

  // Column sums, entries valid once written in this frame
  logic [OUT_COLS-1:0] sum_valid;
  logic [SUM_W-1:0]    ram_rdata;
  logic [SUM_W-1:0]    ram_wdata;
  logic [SUM_W-1:0]    old_sum;
  logic [SUM_W:0]      raw_sum;
  logic [SUM_W-1:0]    new_sum;
  logic [PIX_W-1:0]    pix;

  always_comb begin
    old_sum   = sum_valid[op.grid_col[COL_IDX_W-1:0]] ? ram_rdata : '0;
    raw_sum   = {1'b0, old_sum} + (SUM_W+1)'(pix);
    new_sum   = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
    ram_wdata = op.emit ? '0 : new_sum;
  end

  bavg_ram #(
    .WIDTH (SUM_W),
    .DEPTH (OUT_COLS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (op.grid_col[COL_IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (op_cur.grid_col[COL_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= '0;
    end else if (accept && pixels.frame_start) begin
      sum_valid <= '0;
    end else if (ram_we) begin
      sum_valid[op.grid_col[COL_IDX_W-1:0]] <= 1'b1;
    end
  end

  // Item and scaling datapath
  logic [SUM_W-1:0]  blk_sum;
  logic [PROD_W-1:0] prod;
  logic [DEN_W-1:0]  den;
  logic [AREA_W-1:0] area;

  assign area = AREA_W'(geom.bw) * AREA_W'(geom.bh);

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= op_cur;
      pix <= pixels.pixel;
    end
    if (state == ST_RMW) begin
      blk_sum <= new_sum;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(blk_sum) * PROD_W'(height_scale);
      den  <= {area, 8'b0} - DEN_W'(area);
    end
  end

  bavg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod, {FRAC_W{1'b0}}}),
    .den   (den),
    .cap   ({height_scale, {FRAC_W{1'b0}}}),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      heights.valid <= 1'b0;
    end else if (out_load) begin
      heights.valid <= 1'b1;
    end else if (heights.ready) begin
      heights.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      heights.grid_row      <= op.grid_row;
      heights.grid_col      <= op.grid_col;
      heights.height        <= div_quot;
      heights.last_of_frame <= op.last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bavg_checker.sv
// Port-level checks of the downsampler and their binding to the top level.
`default_nettype none

module bavg_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bavg_pkg::GRID_W-1:0]   grid_row,
  input wire logic [bavg_pkg::GRID_W-1:0]   grid_col,
  input wire logic [bavg_pkg::HEIGHT_W-1:0] height,
  input wire logic                          last_of_frame
);
  import bavg_pkg::*;

  // A stalled height word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(height) && $stable(grid_row)
      && $stable(grid_col) && $stable(last_of_frame))
    else $error("height word changed while stalled");

  // Frame end only on the bottom-right cell
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |->
      grid_row == GRID_W'(OUT_ROWS - 1) && grid_col == GRID_W'(OUT_COLS - 1))
    else $error("last_of_frame away from the final grid cell");

  // One pixel at a time: the memory update follows every accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted during read-modify-write");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind block_average_image_downsampler bavg_checker u_bavg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixels.valid),
  .in_ready      (pixels.ready),
  .out_valid     (heights.valid),
  .out_ready     (heights.ready),
  .grid_row      (heights.grid_row),
  .grid_col      (heights.grid_col),
  .height        (heights.height),
  .last_of_frame (heights.last_of_frame)
);

`default_nettype wire

### sim/block_average_image_downsampler_tb.sv
// Self-checking testbench of the block-average downsampler: directed table, then random frames.
`timescale 1ns / 100ps

module block_average_image_downsampler_tb;
  import bavg_pkg::*;

  // One height word as it leaves the block
  typedef struct packed {
    logic [GRID_W-1:0]   grid_row;
    logic [GRID_W-1:0]   grid_col;
    logic [HEIGHT_W-1:0] height;
    logic                last_of_frame;
  } height_word_t;

  typedef enum logic {
    STEP_CFG,
    STEP_PIXEL
  } step_kind_t;

  // One row of the directed table
  typedef struct packed {
    step_kind_t       kind;
    logic [1:0]       reg_idx;
    logic [31:0]      value;
    logic [15:0]      count;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
    logic             typed;
    height_word_t     want;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;

  bavg_pix_if pix_ch ();
  bavg_res_if res_ch ();

  block_average_image_downsampler uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_ch),
    .heights (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the registers and the frame state
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [HS_W-1:0]  cfg_scale;
  logic [SUM_W-1:0] col_sum [OUT_COLS];
  logic [11:0]      px_col, px_row, col_in_blk, row_in_blk;
  logic [6:0]       blk_col, blk_row;

  height_word_t pending_heights [$];
  plan_step_t   plan [$];
  height_word_t rx_want;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatches = 0;
  int heights_seen = 0;
  int pixels_sent = 0;

  function automatic void clear_counters();
    foreach (col_sum[i]) col_sum[i] = '0;
    px_col = '0;
    px_row = '0;
    col_in_blk = '0;
    row_in_blk = '0;
    blk_col = '0;
    blk_row = '0;
  endfunction

  // Queue helpers
  function automatic void add_step(input plan_step_t s);
    plan.insert(plan.size(), s);
  endfunction

  function automatic void expect_height(input height_word_t word);
    pending_heights.insert(pending_heights.size(), word);
  endfunction

  // Works out the height word (if any) caused by one pixel and advances the raster state
  function automatic bit predict_height(input logic [PIX_W-1:0] pix, input logic fs,
                                        output height_word_t word);
    logic [DIM_W-1:0] w, h;
    logic [6:0]       bw, bh;
    logic             col_end, row_end;
    logic [20:0]      acc;
    logic [47:0]      num, den, quo, cap;
    bit               hit;
    hit = 1'b0;
    word = '0;
    w = cfg_width;
    h = cfg_height;
    if (w > MAX_DIM) w = DIM_W'(MAX_DIM);
    if (h > MAX_DIM) h = DIM_W'(MAX_DIM);
    bw = 7'(w / OUT_COLS);
    bh = 7'(h / OUT_ROWS);
    if (fs) clear_counters();
    col_end = (32'(col_in_blk) + 32'd1) >= 32'(bw);
    row_end = (32'(row_in_blk) + 32'd1) >= 32'(bh);

    // accumulate inside whole blocks only; emit on the block's last pixel
    if (bw != 0 && bh != 0 && blk_col < OUT_COLS && blk_row < OUT_ROWS) begin
      acc = 21'(col_sum[blk_col[5:0]]) + 21'(pix);
      if (acc > 21'(SUM_MAX)) acc = 21'(SUM_MAX);
      col_sum[blk_col[5:0]] = acc[SUM_W-1:0];
      if (col_end && row_end) begin
        num = 48'(acc) * 48'(cfg_scale) * 48'd256;
        den = 48'd255 * 48'(bh) * 48'(bw);
        quo = num / den;
        cap = 48'(cfg_scale) * 48'd256;
        if (quo > cap) quo = cap;
        word.grid_row = blk_row[5:0];
        word.grid_col = blk_col[5:0];
        word.height = quo[HEIGHT_W-1:0];
        word.last_of_frame = (blk_row == OUT_ROWS - 1) && (blk_col == OUT_COLS - 1);
        col_sum[blk_col[5:0]] = '0;
        hit = 1'b1;
      end
    end

    // raster counters; a position past a new limit ends the row or frame
    if (32'(px_col) + 32'd1 >= 32'(w)) begin
      px_col = '0;
      col_in_blk = '0;
      blk_col = '0;
      if (32'(px_row) + 32'd1 >= 32'(h)) begin
        px_row = '0;
        row_in_blk = '0;
        blk_row = '0;
      end else begin
        px_row = px_row + 12'd1;
        if (bh != 0) begin
          if (row_end) begin
            row_in_blk = '0;
            if (blk_row < OUT_ROWS) blk_row = blk_row + 7'd1;
          end else begin
            row_in_blk = row_in_blk + 12'd1;
          end
        end
      end
    end else begin
      px_col = px_col + 12'd1;
      if (bw != 0) begin
        if (col_end) begin
          col_in_blk = '0;
          if (blk_col < OUT_COLS) blk_col = blk_col + 7'd1;
        end else begin
          col_in_blk = col_in_blk + 12'd1;
        end
      end
    end
    return hit;
  endfunction

  // Directed table builders
  function automatic void plan_cfg(input logic [1:0] idx, input logic [31:0] value);
    plan_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.value = value;
    add_step(s);
  endfunction

  function automatic void plan_pix(input int count, input logic [PIX_W-1:0] pixel,
                                   input logic fs);
    plan_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.count = 16'(count);
    s.pixel = pixel;
    s.frame_start = fs;
    add_step(s);
  endfunction

  function automatic void plan_pix_typed(input logic [PIX_W-1:0] pixel, input logic fs,
                                         input int row, input int col, input int height,
                                         input logic last);
    plan_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.count = 16'd1;
    s.pixel = pixel;
    s.frame_start = fs;
    s.typed = 1'b1;
    s.want.grid_row = GRID_W'(row);
    s.want.grid_col = GRID_W'(col);
    s.want.height = HEIGHT_W'(height);
    s.want.last_of_frame = last;
    add_step(s);
  endfunction

  // Register write over APB, only once the block has drained, then read back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [PDATA_W-1:0] want_rd;
    pix_ch.valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_IN_WIDTH: begin
        cfg_width = value[DIM_W-1:0];
        want_rd = PDATA_W'(value[DIM_W-1:0]);
      end
      REG_IN_HEIGHT: begin
        cfg_height = value[DIM_W-1:0];
        want_rd = PDATA_W'(value[DIM_W-1:0]);
      end
      REG_HEIGHT_SCALE: begin
        cfg_scale = value[HS_W-1:0];
        want_rd = PDATA_W'(value[HS_W-1:0]);
      end
      default: want_rd = '0;
    endcase
    // read the register back
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want_rd) begin
      $display("%0t: register %0d readback mismatch: expected %0d, got %0d",
               $time, idx, want_rd, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one pixel word, optionally after a random gap, and log what it should cause
  task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs, input logic typed,
                            input height_word_t want);
    height_word_t word;
    bit           hit;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      pix_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    hit = predict_height(p, fs, word);
    if (typed) expect_height(want);
    else if (hit) expect_height(word);
    pixels_sent++;
  endtask

  task automatic compare_field(input string name, input logic [HEIGHT_W-1:0] want,
                               input logic [HEIGHT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Height word checker and receiver stalls
  always @(posedge clk) begin
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected height word: expected none, got row %0d col %0d height %0d",
                 $time, res_ch.grid_row, res_ch.grid_col, res_ch.height);
        mismatches++;
      end else begin
        rx_want = pending_heights.pop_front();
        compare_field("grid_row", rx_want.grid_row, res_ch.grid_row);
        compare_field("grid_col", rx_want.grid_col, res_ch.grid_col);
        compare_field("height", rx_want.height, res_ch.height);
        compare_field("last_of_frame", rx_want.last_of_frame, res_ch.last_of_frame);
        heights_seen++;
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) < rx_stall_pct) ? 1'b0 : 1'b1;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("block_average_image_downsampler_tb: FAIL");
    $finish;
  end

  initial begin
    int               k, phase, burst, profile, random_sent;
    logic [31:0]      w_val, h_val, hs_val;
    logic [PIX_W-1:0] p;
    logic             fs;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    pix_ch.frame_start <= 1'b0;
    cfg_width = IN_WIDTH_RST;
    cfg_height = IN_HEIGHT_RST;
    cfg_scale = HEIGHT_SCALE_RST;
    clear_counters();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // one pixel per block, full scale
    plan_cfg(REG_IN_WIDTH, 64);
    plan_cfg(REG_IN_HEIGHT, 64);
    plan_cfg(REG_HEIGHT_SCALE, 1023);
    plan_pix_typed(8'd255, 1'b1, 0, 0, 261888, 1'b0);
    plan_pix_typed(8'd0, 1'b0, 0, 1, 0, 1'b0);
    plan_pix(1, 8'd1, 1'b0);
    plan_pix(1, 8'd128, 1'b1);
    plan_cfg(REG_HEIGHT_SCALE, 0);
    plan_pix_typed(8'd255, 1'b0, 0, 1, 0, 1'b0);
    plan_cfg(REG_HEIGHT_SCALE, 1);
    plan_pix_typed(8'd255, 1'b0, 0, 2, 256, 1'b0);
    // zero block width: every pixel is a row, walk down to the last grid row
    plan_cfg(REG_IN_WIDTH, 1);
    plan_pix(1, 8'd7, 1'b1);
    plan_pix(62, 8'd7, 1'b0);
    // widen again mid-frame and finish the bottom grid row
    plan_cfg(REG_IN_WIDTH, 64);
    plan_pix(63, 8'd255, 1'b0);
    plan_pix_typed(8'd255, 1'b0, 63, 63, 256, 1'b1);
    // frame wraps without frame_start
    plan_pix_typed(8'd0, 1'b0, 0, 0, 0, 1'b0);
    // block shrinks mid-block: sum over the area, height capped
    plan_cfg(REG_IN_WIDTH, 128);
    plan_pix(1, 8'd255, 1'b1);
    plan_cfg(REG_IN_WIDTH, 64);
    plan_pix_typed(8'd255, 1'b0, 0, 0, 256, 1'b0);
    // oversized dimensions count as the maximum
    plan_cfg(REG_IN_WIDTH, 8191);
    plan_cfg(REG_IN_HEIGHT, 8191);
    plan_pix(4, 8'd200, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        for (k = 0; k < plan[i].count; k++)
          send_pixel(plan[i].pixel, plan[i].frame_start && k == 0, plan[i].typed,
                     plan[i].want);
      end
    end

    // random phases: mostly small blocks so heights come often
    random_sent = 0;
    phase = 0;
    while (random_sent < 800) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      profile = $urandom_range(0, 9);
      if (profile <= 6) begin
        w_val = $urandom_range(64, 191);
        h_val = $urandom_range(64, 191);
      end else if (profile == 7) begin
        w_val = ($urandom_range(0, 3) == 0) ? 8191 : $urandom_range(0, 8191);
        h_val = $urandom_range(64, 127);
      end else if (profile == 8) begin
        w_val = $urandom_range(64, 127);
        h_val = ($urandom_range(0, 3) == 0) ? 8191 : $urandom_range(0, 8191);
      end else begin
        w_val = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
        h_val = $urandom_range(0, 8191);
      end
      case ($urandom_range(0, 3))
        0: hs_val = 0;
        1: hs_val = 1023;
        default: hs_val = $urandom_range(0, 1023);
      endcase
      write_reg(REG_IN_WIDTH, w_val);
      write_reg(REG_IN_HEIGHT, h_val);
      write_reg(REG_HEIGHT_SCALE, hs_val);

      burst = $urandom_range(10, 100);
      for (k = 0; k < burst; k++) begin
        case ($urandom_range(0, 7))
          0: p = 8'd0;
          1: p = 8'd255;
          default: p = PIX_W'($urandom_range(0, 255));
        endcase
        fs = (k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 63) == 0);
        send_pixel(p, fs, 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    // drain
    pix_ch.valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d pixel words over %0d random phases plus the directed table,",
             pixels_sent, phase);
    $display("checked %0d height words across small, empty and oversized block geometries.",
             heights_seen);
    if (mismatches == 0) begin
      $display("block_average_image_downsampler_tb: PASS");
    end else begin
      $display("block_average_image_downsampler_tb: FAIL");
    end
    $finish;
  end

endmodule
